### src/sdcs_pkg.sv
// Shared constants, types and register indexes of the strided DMA chunk splitter.
`timescale 1ns / 1ps
`default_nettype none

package sdcs_pkg;

    localparam int ADDR_WIDTH    = 48;
    localparam int PAGE_SIZE     = 4096;
    localparam int MAX_ROW_BYTES = 2048;

    localparam int PAGE_BITS = $clog2(PAGE_SIZE);
    localparam int LEN_W     = (PAGE_BITS + 1 > 13) ? PAGE_BITS + 1 : 13;
    localparam int CFG_W     = 48;

    typedef logic [ADDR_WIDTH-1:0] t_addr;

    typedef enum logic [2:0] {
        CFG_BASE_ADDRESS    = 3'd0,
        CFG_ROW_STRIDE      = 3'd1,
        CFG_ROW_BYTES       = 3'd2,
        CFG_ROW_COUNT       = 3'd3,
        CFG_MAX_CHUNK_BYTES = 3'd4,
        CFG_BLOCK_SIZE_LOG2 = 3'd5
    } t_cfg_index;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic step;
    } t_dp_cmd;

    typedef struct packed {
        logic row_ok;
        logic last_chunk;
    } t_dp_status;

endpackage

`default_nettype wire

### src/sdcs_ctrl.sv
// Controller state machine sequencing the chunks of one row.
`timescale 1ns / 1ps
`default_nettype none

module sdcs_ctrl (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    output logic                    o_valid,
    input  wire                     i_ready,
    input  sdcs_pkg::t_dp_status    i_status,
    output sdcs_pkg::t_dp_cmd       o_cmd
);
    import sdcs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && i_status.row_ok) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_ready && i_status.last_chunk) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready    = 1'b0;
        o_valid    = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.start = i_valid;
            end
            ST_EMIT: begin
                o_valid    = 1'b1;
                o_cmd.step = i_ready;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/sdcs_datapath.sv
// Datapath: configuration registers, row state and chunk length selection.
`timescale 1ns / 1ps
`default_nettype none

module sdcs_datapath (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire  [2:0]              i_cfg_index,
    input  wire  [sdcs_pkg::CFG_W-1:0] i_cfg_data,
    input  wire                     i_restart,
    input  sdcs_pkg::t_dp_cmd       i_cmd,
    output sdcs_pkg::t_dp_status    o_status,
    output logic [47:0]             o_chunk_address,
    output logic [11:0]             o_chunk_size,
    output logic [15:0]             o_row_index,
    output logic [10:0]             o_row_offset,
    output logic                    o_last_in_row,
    output logic                    o_final_row
);
    import sdcs_pkg::*;

    logic [47:0] r_base;
    logic [31:0] r_stride;
    logic [11:0] r_row_bytes;
    logic [15:0] r_row_count;
    logic [12:0] r_max_chunk;
    logic [3:0]  r_blk_log2;

    logic [15:0] r_next_row;
    t_addr       r_row_start;

    t_addr       r_addr;
    logic [11:0] r_done;
    logic [15:0] r_cur_row;
    logic        r_final;

    logic [11:0]      rb;
    logic [12:0]      maxc;
    logic [3:0]       blk_log2;
    logic [12:0]      blk;
    logic [15:0]      eff_row;
    t_addr            row_start;
    logic             row_ok;
    logic [11:0]      rem;
    logic [LEN_W-1:0] to_page;
    logic [12:0]      to_blk;
    logic [LEN_W-1:0] len_w;
    logic [11:0]      len;
    logic [12:0]      done_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_stride    <= '0;
            r_row_bytes <= '0;
            r_row_count <= '0;
            r_max_chunk <= 13'd64;
            r_blk_log2  <= 4'd6;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE_ADDRESS:    r_base      <= i_cfg_data[47:0];
                CFG_ROW_STRIDE:      r_stride    <= i_cfg_data[31:0];
                CFG_ROW_BYTES:       r_row_bytes <= i_cfg_data[11:0];
                CFG_ROW_COUNT:       r_row_count <= i_cfg_data[15:0];
                CFG_MAX_CHUNK_BYTES: r_max_chunk <= i_cfg_data[12:0];
                CFG_BLOCK_SIZE_LOG2: r_blk_log2  <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        rb = (r_row_bytes > 12'(MAX_ROW_BYTES)) ? 12'(MAX_ROW_BYTES) : r_row_bytes;
        if (r_max_chunk < 13'd64) begin
            maxc = 13'd64;
        end else if (r_max_chunk > 13'd4096) begin
            maxc = 13'd4096;
        end else begin
            maxc = r_max_chunk;
        end
        if (r_blk_log2 < 4'd6) begin
            blk_log2 = 4'd6;
        end else if (r_blk_log2 > 4'd12) begin
            blk_log2 = 4'd12;
        end else begin
            blk_log2 = r_blk_log2;
        end
        blk = 13'd1 << blk_log2;

        eff_row   = i_restart ? 16'd0 : r_next_row;
        row_start = (eff_row == 16'd0) ? t_addr'(r_base) : r_row_start;
        row_ok    = (rb != 12'd0) && (r_row_count != 16'd0)
                    && !((r_stride != 32'd0) && (r_stride < 32'(rb)))
                    && (eff_row < r_row_count);

        rem     = rb - r_done;
        to_page = LEN_W'(PAGE_SIZE) - LEN_W'(r_addr[PAGE_BITS-1:0]);
        to_blk  = blk - (r_addr[12:0] & (blk - 13'd1));
        len_w   = LEN_W'(rem);
        if (to_page < len_w) begin
            len_w = to_page;
        end
        if (LEN_W'(to_blk) < len_w) begin
            len_w = LEN_W'(to_blk);
        end
        if (LEN_W'(maxc) < len_w) begin
            len_w = LEN_W'(maxc);
        end
        len      = len_w[11:0];
        done_sum = 13'(r_done) + 13'(len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_row  <= '0;
            r_row_start <= '0;
        end else if (i_cmd.start) begin
            r_next_row  <= row_ok ? eff_row + 16'd1 : eff_row;
            r_row_start <= row_ok ? row_start + t_addr'(r_stride) : row_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_done    <= '0;
            r_cur_row <= '0;
            r_final   <= 1'b0;
        end else if (i_cmd.start) begin
            r_addr    <= row_start;
            r_done    <= '0;
            r_cur_row <= eff_row;
            r_final   <= (17'(eff_row) + 17'd1) == 17'(r_row_count);
        end else if (i_cmd.step) begin
            r_addr <= r_addr + t_addr'(len);
            r_done <= r_done + len;
        end
    end

    assign o_status.row_ok     = row_ok;
    assign o_status.last_chunk = done_sum >= 13'(rb);

    assign o_chunk_address = 48'(r_addr);
    assign o_chunk_size    = len;
    assign o_row_index     = r_cur_row;
    assign o_row_offset    = r_done[10:0];
    assign o_last_in_row   = o_status.last_chunk;
    assign o_final_row     = r_final;

endmodule

`default_nettype wire

### src/strided_dma_chunk_splitter.sv
// Top level of the strided DMA chunk splitter.
// An accepted word yields its row's chunks, one per cycle while i_ready is high, from the cycle after acceptance.
// A row's chunks occupy the splitter until the last one is taken; no new word is accepted before then.
// A word that yields no chunk is accepted and leaves the splitter ready for the next word.
// Synchronous active-low reset restores register defaults and returns to row 0.
`timescale 1ns / 1ps
`default_nettype none

module strided_dma_chunk_splitter (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire  [2:0]                 i_cfg_index,
    input  wire  [sdcs_pkg::CFG_W-1:0] i_cfg_data,
    input  wire                        i_valid,
    output logic                       o_ready,
    input  wire                        i_restart,
    output logic                       o_valid,
    input  wire                        i_ready,
    output logic [47:0]                o_chunk_address,
    output logic [11:0]                o_chunk_size,
    output logic [15:0]                o_row_index,
    output logic [10:0]                o_row_offset,
    output logic                       o_last_in_row,
    output logic                       o_final_row
);
    import sdcs_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    sdcs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    sdcs_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_restart       (i_restart),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .o_chunk_address (o_chunk_address),
        .o_chunk_size    (o_chunk_size),
        .o_row_index     (o_row_index),
        .o_row_offset    (o_row_offset),
        .o_last_in_row   (o_last_in_row),
        .o_final_row     (o_final_row)
    );

endmodule

`default_nettype wire

### src/sdcs_checker.sv
// Port-level assertions for the strided DMA chunk splitter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sdcs_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_ready,
    input wire        o_valid,
    input wire        i_ready,
    input wire [47:0] o_chunk_address,
    input wire [11:0] o_chunk_size,
    input wire [15:0] o_row_index,
    input wire [10:0] o_row_offset,
    input wire        o_last_in_row
);

    // A stalled output word holds its address and size.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_chunk_address) && $stable(o_chunk_size))
        else $error("output word changed while stalled");

    // Rows are handled one at a time.
    a_one_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("input taken while chunks are pending");

    a_size_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_chunk_size != 12'd0)
        else $error("empty chunk emitted");

    // Within a row, each chunk follows on directly from the previous one.
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_in_row |=> o_valid && $stable(o_row_index)
            && (o_row_offset == 11'($past(o_row_offset) + 11'($past(o_chunk_size))))
            && (o_chunk_address == 48'($past(o_chunk_address) + 48'($past(o_chunk_size)))))
        else $error("chunks of a row are not contiguous");

endmodule

bind strided_dma_chunk_splitter sdcs_checker u_sdcs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_chunk_address (o_chunk_address),
    .o_chunk_size    (o_chunk_size),
    .o_row_index     (o_row_index),
    .o_row_offset    (o_row_offset),
    .o_last_in_row   (o_last_in_row)
);

`default_nettype wire
